[src/scf_pkg.sv]
// Shared types, codes and the raised-cosine weight table for the crossfade interpolator.
`default_nettype none

package scf_pkg;

   localparam int VALUE_BITS       = 16;
   localparam int LIMIT_BITS       = 16;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
   localparam int DIFF_BITS        = VALUE_BITS + 1;
   localparam int PROD_BITS        = WEIGHT_BITS + 1 + DIFF_BITS;
   localparam int ITER_BITS        = $clog2(WEIGHT_FRAC_BITS + 1);
   localparam int CSR_INDEX_BITS   = 1;

   localparam int COS_TABLE_STEPS  = 256;
   localparam int COS_SHIFT_BITS   = $clog2(COS_TABLE_STEPS);
   localparam int COS_INDEX_BITS   = $clog2(COS_TABLE_STEPS + 1);

   localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;

   // Operation codes
   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_BLEND   = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EASING_MODE = 1'b1;

   localparam logic [63:0] PI_Q30    = 64'd3373259426;
   localparam logic [63:0] HALF_Q30  = 64'd1 << 29;
   localparam logic [63:0] HALF_Q44  = 64'd1 << 43;
   localparam logic [63:0] TableSpan = 64'(2 * COS_TABLE_STEPS);

   typedef logic [63:0] series_div_type [1:8];
   // (2k)(2k+1) for the sine series terms
   localparam series_div_type SeriesDivisor = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   typedef struct packed {
      logic [1:0]                   op;
      logic signed [VALUE_BITS-1:0] start_value;
      logic signed [VALUE_BITS-1:0] end_value;
      logic                         last_element;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] blended_value;
      logic                         done_res;
      logic                         last;
   } rsp_payload_type;

   typedef logic [WEIGHT_BITS-1:0] cos_rom_type [0:COS_TABLE_STEPS];

   // Build sin^2(pi*i/(2N)) in Q1.16 from a Q2.30 sine series; elaboration only.
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic        neg;
      for (int i = 0; i <= COS_TABLE_STEPS; i++) begin
         if (i == 0) begin
            rom[i] = '0;
         end else if (i == COS_TABLE_STEPS) begin
            rom[i] = ONE_Q16;
         end else begin
            x    = (PI_Q30 * 64'(i) + 64'(COS_TABLE_STEPS)) / TableSpan;
            x2   = (x * x + HALF_Q30) >> 30;
            term = x;
            sum  = x;
            neg  = 1'b1;
            for (int k = 1; k <= 8; k++) begin
               term = ((term * x2) >> 30) / SeriesDivisor[k];
               if (neg) begin
                  sum = (sum >= term) ? sum - term : 64'd0;
               end else begin
                  sum = sum + term;
               end
               neg = ~neg;
            end
            sum = (sum * sum + HALF_Q44) >> 44;
            rom[i] = (sum > 64'(ONE_Q16)) ? ONE_Q16 : sum[WEIGHT_BITS-1:0];
         end
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

[src/step_crossfade_interpolator_top.sv]
// Crossfade interpolator: step counter, shared restoring divider, weight table and blend.
//
//  channel  direction  ports                          transfer when
//  req      in         req_valid req_ready req_data   req_valid & req_ready
//  rsp      out        rsp_valid rsp_ready rsp_data   rsp_valid & rsp_ready
//  csr      in         csr_we csr_index csr_wdata     csr_we
//
// Restart, advance and unused ops go through the emit step to the result register.
// A blend in either mode uses the shared divider, which retires one quotient bit per cycle
// (16 bits in linear mode, 8 in cosine mode), then weight select, multiply, round.
// A blend past the step limit skips the divider and weight select and uses weight one.
// Synchronous reset clears count, limit to 1 and linear mode; no clearing pass.
// The result register frees the core: a new item is taken while a result waits,
// and a finished item stalls only until the result register is empty.
`default_nettype none

module step_crossfade_interpolator_top
   import scf_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  req_payload_type                req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output rsp_payload_type                rsp_data,
   input  wire                            csr_we,
   input  wire  [CSR_INDEX_BITS-1:0]      csr_index,
   input  wire  [LIMIT_BITS-1:0]          csr_wdata
);

   localparam int CmpW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_FIX  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam cos_rom_type CosRom = build_cos_rom();

   logic [2:0]                   state_ff,   state_in;
   logic [COUNT_BITS-1:0]        count_ff,   count_in;
   logic [LIMIT_BITS-1:0]        limit_ff;
   logic                         mode_ff;
   logic [ITER_BITS-1:0]         iter_ff,    iter_in;
   logic [LIMIT_BITS:0]          rem_ff,     rem_in;
   logic [WEIGHT_FRAC_BITS-1:0]  quo_ff,     quo_in;
   logic [WEIGHT_BITS-1:0]       weight_ff,  weight_in;
   logic signed [DIFF_BITS-1:0]  diff_ff,    diff_in;
   logic signed [VALUE_BITS-1:0] start_ff,   start_in;
   logic                         last_ff,    last_in;
   logic                         blend_ff,   blend_in;
   logic signed [PROD_BITS-1:0]  product_ff, product_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_data_ff,  rsp_data_in;

   logic                         req_xfer;
   logic                         out_free;
   logic [CmpW-1:0]              count_ext;
   logic [CmpW-1:0]              limit_ext;
   logic                         at_limit;
   logic [LIMIT_BITS:0]          rem_shift;
   logic                         rem_ge;
   logic [LIMIT_BITS:0]          half_sum;
   logic                         round_up;
   logic [COS_INDEX_BITS-1:0]    cos_idx;
   logic signed [PROD_BITS-1:0]  round_sum;
   logic signed [VALUE_BITS-1:0] blended;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign count_ext = CmpW'(count_ff);
   assign limit_ext = CmpW'(limit_ff);
   assign at_limit  = (count_ext >= limit_ext);

   // One restoring step: remainder stays below the limit
   assign rem_shift = {rem_ff[LIMIT_BITS-1:0], 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, limit_ff});

   // Round the cosine index to nearest: add half the limit to the remainder
   assign half_sum = rem_ff + {2'b00, limit_ff[LIMIT_BITS-1:1]};
   assign round_up = (half_sum >= {1'b0, limit_ff});
   assign cos_idx  = quo_ff[COS_INDEX_BITS-1:0] + COS_INDEX_BITS'(round_up);

   assign round_sum = product_ff + PROD_BITS'(signed'(33'sd32768));
   assign blended   = start_ff
                    + round_sum[WEIGHT_FRAC_BITS+VALUE_BITS-1:WEIGHT_FRAC_BITS];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      weight_in    = weight_ff;
      diff_in      = diff_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      blend_in     = blend_ff;
      product_in   = product_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               blend_in = 1'b0;
               state_in = ST_EMIT;
               unique case (req_data.op)
                  OP_RESTART: count_in = '0;
                  OP_ADVANCE: begin
                     if (count_ff != '1) begin
                        count_in = count_ff + COUNT_BITS'(1);
                     end
                  end
                  OP_BLEND: begin
                     blend_in = 1'b1;
                     start_in = req_data.start_value;
                     last_in  = req_data.last_element;
                     diff_in  = DIFF_BITS'(req_data.end_value)
                              - DIFF_BITS'(req_data.start_value);
                     if (at_limit) begin
                        weight_in = ONE_Q16;
                        state_in  = ST_MUL;
                     end else begin
                        rem_in   = {1'b0, count_ext[LIMIT_BITS-1:0]};
                        quo_in   = '0;
                        iter_in  = mode_ff ? ITER_BITS'(COS_SHIFT_BITS)
                                           : ITER_BITS'(WEIGHT_FRAC_BITS);
                        state_in = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_shift - {1'b0, limit_ff} : rem_shift;
            quo_in  = {quo_ff[WEIGHT_FRAC_BITS-2:0], rem_ge};
            iter_in = iter_ff - ITER_BITS'(1);
            if (iter_ff == ITER_BITS'(1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            weight_in = mode_ff ? CosRom[cos_idx] : {1'b0, quo_ff};
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            product_in = $signed({1'b0, weight_ff}) * diff_ff;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.blended_value = blend_ff ? blended : '0;
               rsp_data_in.done_res      = at_limit;
               rsp_data_in.last          = blend_ff && last_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_BITS'(1);
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blend_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         blend_ff     <= blend_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_STEP_LIMIT:  limit_ff <= csr_wdata;
               REG_EASING_MODE: mode_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      weight_ff   <= weight_in;
      diff_ff     <= diff_in;
      start_ff    <= start_in;
      last_ff     <= last_in;
      product_ff  <= product_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_rem_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < {1'b0, limit_ff}))
      else $error("divider remainder reached the limit");

   a_cos_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX && mode_ff) |-> (cos_idx <= COS_INDEX_BITS'(COS_TABLE_STEPS)))
      else $error("cosine table index out of range");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.op != OP_RESTART) |=> (count_ff >= $past(count_ff)))
      else $error("step count fell without a restart");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result raised outside the emit step");

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (weight_ff <= ONE_Q16))
      else $error("blend weight above one");
`endif

endmodule

`default_nettype wire
